[rtl/stm_pkg.sv]
package stm_pkg;

	localparam int ScreenWidth = 320;
	localparam int TileBits    = 6;
	localparam int TileIdxW    = 2 * TileBits;
	localparam int TileDepth   = 1 << TileIdxW;
	localparam int MapIdxW     = 8;
	localparam int MapDepth    = 1 << MapIdxW;
	localparam int AddrW       = 17;
	localparam int TopMargin   = 20;
	localparam int RowSumW     = 9;
	localparam int BaseW       = RowSumW + $clog2(ScreenWidth) + 1;
	localparam int FracBits    = 16;
	localparam int QDepth      = 4;
	localparam int QPtrW       = $clog2(QDepth);

	typedef enum logic [1:0] {
		REQ_TILE    = 2'd0,
		REQ_LIGHT   = 2'd1,
		REQ_PALETTE = 2'd2,
		REQ_DRAW    = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		CFG_LOW_DETAIL = 2'd0,
		CFG_WINDOW_X   = 2'd1,
		CFG_WINDOW_Y   = 2'd2,
		CFG_UNUSED     = 2'd3
	} cfg_t;

	// one queued operation: table write, or a draw with its texel index and address
	typedef struct packed {
		req_t                kind;
		logic [TileIdxW-1:0] index;
		logic [31:0]         data;
		logic [AddrW-1:0]    addr;
		logic                wide;
	} op_t;

endpackage

[rtl/stm_ram.sv]
module stm_ram #(
	parameter int Width = 8,
	parameter int Depth = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];
	logic [Width-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

[rtl/stm_front.sv]
module stm_front (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [7:0]   cfg_data,
	input  logic         accept,
	input  logic [1:0]   req_type,
	input  logic [11:0]  table_index,
	input  logic [31:0]  table_data,
	input  logic         span_start,
	input  logic [31:0]  u_start,
	input  logic [31:0]  v_start,
	input  logic [31:0]  u_step,
	input  logic [31:0]  v_step,
	input  logic [8:0]   x_first,
	input  logic [7:0]   row_in_view,
	output stm_pkg::op_t push_op
);
	import stm_pkg::*;

	logic                low_detail_q;
	logic [7:0]          window_x_q;
	logic [6:0]          window_y_q;
	logic [31:0]         u_q, v_q, du_q, dv_q;
	logic [AddrW-1:0]    next_addr_q;

	req_t                kind;
	logic                draw;
	logic                load;
	logic [RowSumW-1:0]  row_sum;
	logic [BaseW-1:0]    base_full;
	logic [AddrW-1:0]    start_addr;
	logic [AddrW-1:0]    addr_cur;
	logic [31:0]         u_cur, v_cur, du_cur, dv_cur;
	logic [TileIdxW-1:0] texel_idx;

	assign kind = req_t'(req_type);
	assign draw = (kind == REQ_DRAW);
	assign load = draw && span_start;

	assign row_sum = RowSumW'(window_y_q) + RowSumW'(TopMargin) + RowSumW'(row_in_view);
	assign base_full = BaseW'(row_sum) * BaseW'(ScreenWidth) + BaseW'(window_x_q)
		+ (low_detail_q ? BaseW'({x_first, 1'b0}) : BaseW'(x_first));
	assign start_addr = base_full[AddrW-1:0];

	assign addr_cur = load ? start_addr : next_addr_q;
	assign u_cur    = load ? u_start : u_q;
	assign v_cur    = load ? v_start : v_q;
	assign du_cur   = load ? u_step : du_q;
	assign dv_cur   = load ? v_step : dv_q;

	// tile row from v, column from u, both wrap
	assign texel_idx = {v_cur[FracBits +: TileBits], u_cur[FracBits +: TileBits]};

	always_comb begin
		push_op.kind  = kind;
		push_op.index = draw ? texel_idx : TileIdxW'(table_index);
		push_op.data  = table_data;
		push_op.addr  = addr_cur;
		push_op.wide  = low_detail_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_detail_q <= 1'b0;
			window_x_q   <= '0;
			window_y_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_t'(cfg_index))
				CFG_LOW_DETAIL: low_detail_q <= cfg_data[0];
				CFG_WINDOW_X:   window_x_q   <= cfg_data;
				CFG_WINDOW_Y:   window_y_q   <= cfg_data[6:0];
				default:        ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			u_q         <= '0;
			v_q         <= '0;
			du_q        <= '0;
			dv_q        <= '0;
			next_addr_q <= '0;
		end else if (accept && draw) begin
			u_q         <= u_cur + du_cur;
			v_q         <= v_cur + dv_cur;
			du_q        <= du_cur;
			dv_q        <= dv_cur;
			next_addr_q <= addr_cur + (low_detail_q ? AddrW'(2) : AddrW'(1));
		end
	end
endmodule

[rtl/stm_queue.sv]
module stm_queue (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  stm_pkg::op_t push_op,
	output logic         full,
	input  logic         pop,
	output logic         not_empty,
	output stm_pkg::op_t head_op
);
	import stm_pkg::*;

	op_t              entry_q [QDepth];
	logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPtrW:0]   count_q;

	assign full      = (count_q == (QPtrW+1)'(QDepth));
	assign not_empty = (count_q != '0);
	assign head_op   = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end
endmodule

[rtl/stm_back.sv]
module stm_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   q_valid,
	input  stm_pkg::op_t           q_op,
	output logic                   q_pop,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [stm_pkg::AddrW-1:0] pixel_address,
	output logic [31:0]            pixel_data,
	output logic                   wide_write
);
	import stm_pkg::*;

	logic             adv;
	logic             valid_s1, valid_s2;
	op_t              op_s1, op_s2;
	logic             out_valid_q;
	logic [AddrW-1:0] out_addr_q;
	logic             out_wide_q;
	logic [7:0]       tile_rdata;
	logic [7:0]       light_rdata;

	// whole pipe moves together; RAM read regs hold while stalled
	assign adv   = !out_valid_q || out_ready;
	assign q_pop = q_valid && adv;

	// each table is written at the stage where draws read it, keeping word order
	stm_ram #(.Width(8), .Depth(TileDepth)) u_tile (
		.clk   (clk),
		.we    (q_pop && q_op.kind == REQ_TILE),
		.waddr (q_op.index),
		.wdata (q_op.data[7:0]),
		.re    (adv),
		.raddr (q_op.index),
		.rdata (tile_rdata)
	);

	stm_ram #(.Width(8), .Depth(MapDepth)) u_light (
		.clk   (clk),
		.we    (adv && valid_s1 && op_s1.kind == REQ_LIGHT),
		.waddr (op_s1.index[MapIdxW-1:0]),
		.wdata (op_s1.data[7:0]),
		.re    (adv),
		.raddr (tile_rdata),
		.rdata (light_rdata)
	);

	stm_ram #(.Width(32), .Depth(MapDepth)) u_palette (
		.clk   (clk),
		.we    (adv && valid_s2 && op_s2.kind == REQ_PALETTE),
		.waddr (op_s2.index[MapIdxW-1:0]),
		.wdata (op_s2.data),
		.re    (adv),
		.raddr (light_rdata),
		.rdata (pixel_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s1    <= q_valid;
			valid_s2    <= valid_s1;
			out_valid_q <= valid_s2 && op_s2.kind == REQ_DRAW;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s1      <= q_op;
			op_s2      <= op_s1;
			out_addr_q <= op_s2.addr;
			out_wide_q <= op_s2.wide;
		end
	end

	assign out_valid     = out_valid_q;
	assign pixel_address = out_addr_q;
	assign wide_write    = out_wide_q;
endmodule

[rtl/span_texture_map.sv]
// Affine floor/ceiling span texture mapper. Table words (req_type 0..2) load the
// 64x64 texel tile, the light map and the palette; draw words (req_type 3) give one
// pixel each, palette[light_map[tile[v row][u column]]], at the next framebuffer
// address. Words are taken at one per clock while the queue is not full: the front
// end steps the 16.16 u/v accumulators and the address in an add loop through the
// span registers, and the back end reads each table RAM once per word through its
// one read port. A draw word goes through the queue and registered tile, light and
// palette reads to the output; the four-entry queue keeps input flowing while the
// output is stalled, until it fills. Table and draw words stay in order, so a table
// write affects only later draws. The tables come up undefined after reset and must
// be loaded before they are drawn from; the span registers and configuration reset
// to zero. Configuration must be written only while idle; this is not enforced.
module span_texture_map (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [1:0]                cfg_index,
	input  logic [7:0]                cfg_data,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [1:0]                req_type,
	input  logic [11:0]               table_index,
	input  logic [31:0]               table_data,
	input  logic                      span_start,
	input  logic [31:0]               u_start,
	input  logic [31:0]               v_start,
	input  logic [31:0]               u_step,
	input  logic [31:0]               v_step,
	input  logic [8:0]                x_first,
	input  logic [7:0]                row_in_view,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [stm_pkg::AddrW-1:0] pixel_address,
	output logic [31:0]               pixel_data,
	output logic                      wide_write
);
	import stm_pkg::*;

	logic accept;
	logic q_full;
	logic q_not_empty;
	logic q_pop;
	op_t  push_op;
	op_t  head_op;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	stm_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.accept      (accept),
		.req_type    (req_type),
		.table_index (table_index),
		.table_data  (table_data),
		.span_start  (span_start),
		.u_start     (u_start),
		.v_start     (v_start),
		.u_step      (u_step),
		.v_step      (v_step),
		.x_first     (x_first),
		.row_in_view (row_in_view),
		.push_op     (push_op)
	);

	stm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_op   (push_op),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.head_op   (head_op)
	);

	stm_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_not_empty),
		.q_op          (head_op),
		.q_pop         (q_pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.pixel_address (pixel_address),
		.pixel_data    (pixel_data),
		.wide_write    (wide_write)
	);
endmodule

[sim/span_texture_map_tb.sv]
`timescale 1ns / 1ps

module span_texture_map_tb;
	import stm_pkg::*;

	localparam int CycleLimit  = 2_000_000;
	localparam int DrainCycles = 12;
	localparam int PhaseWords  = 110;

	typedef struct {
		req_t        kind;
		logic [11:0] index;
		logic [31:0] data;
		logic        start;
		logic [31:0] u0;
		logic [31:0] v0;
		logic [31:0] du;
		logic [31:0] dv;
		logic [8:0]  x;
		logic [7:0]  row;
	} word_t;

	typedef struct {
		logic [AddrW-1:0] addr;
		logic [31:0]      data;
		logic             wide;
	} pixel_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_we = 1'b0;
	logic [1:0]       cfg_index = '0;
	logic [7:0]       cfg_data = '0;
	logic             in_valid = 1'b0;
	logic             in_ready;
	logic [1:0]       req_type = '0;
	logic [11:0]      table_index = '0;
	logic [31:0]      table_data = '0;
	logic             span_start = 1'b0;
	logic [31:0]      u_start = '0;
	logic [31:0]      v_start = '0;
	logic [31:0]      u_step = '0;
	logic [31:0]      v_step = '0;
	logic [8:0]       x_first = '0;
	logic [7:0]       row_in_view = '0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	logic [AddrW-1:0] pixel_address;
	logic [31:0]      pixel_data;
	logic             wide_write;

	span_texture_map i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.req_type     (req_type),
		.table_index  (table_index),
		.table_data   (table_data),
		.span_start   (span_start),
		.u_start      (u_start),
		.v_start      (v_start),
		.u_step       (u_step),
		.v_step       (v_step),
		.x_first      (x_first),
		.row_in_view  (row_in_view),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.pixel_address(pixel_address),
		.pixel_data   (pixel_data),
		.wide_write   (wide_write)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// shadow copy of the mapper: tables, span registers, configuration
	bit [7:0]       tile_mem  [TileDepth];
	bit             tile_set  [TileDepth];
	bit [7:0]       light_mem [MapDepth];
	bit             light_set [MapDepth];
	bit [31:0]      pal_mem   [MapDepth];
	bit             pal_set   [MapDepth];
	bit [31:0]      u_acc, v_acc, u_inc, v_inc;
	bit [AddrW-1:0] addr_acc;
	bit             detail_low;
	bit [7:0]       win_x;
	bit [6:0]       win_y;

	pixel_t      expected_pixels[$];
	int unsigned errors;
	int unsigned pixels_checked;
	int unsigned table_writes;
	int unsigned spans_started;
	int unsigned words_sent;
	int unsigned stall_left;
	int unsigned cycle_count;
	bit          quiet;

	function automatic int unsigned pick_gap();
		int unsigned r = $urandom_range(0, 99);
		if (quiet || r < 60)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic logic [31:0] small_step();
		return $urandom_range(0, 32'h3FFFF) - 32'h1FFFF;
	endfunction

	function automatic word_t random_word(req_t kind);
		word_t w;
		w.kind  = kind;
		w.index = 12'($urandom);
		w.data  = $urandom;
		w.start = 1'($urandom);
		w.u0    = $urandom;
		w.v0    = $urandom;
		w.du    = $urandom;
		w.dv    = $urandom;
		w.x     = 9'($urandom_range(0, 319));
		w.row   = 8'($urandom_range(0, 199));
		return w;
	endfunction

	// tile entry a draw word will read, after its span load if any
	function automatic logic [TileIdxW-1:0] texel_of(word_t w);
		logic [31:0] u = w.start ? w.u0 : u_acc;
		logic [31:0] v = w.start ? w.v0 : v_acc;
		return {v[FracBits +: TileBits], u[FracBits +: TileBits]};
	endfunction

	function automatic void predict_word(word_t w);
		pixel_t               p;
		int unsigned          base;
		logic [TileIdxW-1:0]  t;
		case (w.kind)
			REQ_TILE: begin
				tile_mem[w.index[TileIdxW-1:0]] = w.data[7:0];
				tile_set[w.index[TileIdxW-1:0]] = 1'b1;
				table_writes++;
			end
			REQ_LIGHT: begin
				light_mem[w.index[MapIdxW-1:0]] = w.data[7:0];
				light_set[w.index[MapIdxW-1:0]] = 1'b1;
				table_writes++;
			end
			REQ_PALETTE: begin
				pal_mem[w.index[MapIdxW-1:0]] = w.data;
				pal_set[w.index[MapIdxW-1:0]] = 1'b1;
				table_writes++;
			end
			default: begin
				if (w.start) begin
					u_acc = w.u0;
					v_acc = w.v0;
					u_inc = w.du;
					v_inc = w.dv;
					base = (int'(win_y) + TopMargin + int'(w.row)) * ScreenWidth + int'(win_x)
						+ (detail_low ? 2 * int'(w.x) : int'(w.x));
					addr_acc = AddrW'(base);
					spans_started++;
				end
				t = {v_acc[FracBits +: TileBits], u_acc[FracBits +: TileBits]};
				p.addr = addr_acc;
				p.data = pal_mem[light_mem[tile_mem[t]]];
				p.wide = detail_low;
				expected_pixels.push_back(p);
				u_acc = u_acc + u_inc;
				v_acc = v_acc + v_inc;
				addr_acc = addr_acc + (detail_low ? AddrW'(2) : AddrW'(1));
			end
		endcase
	endfunction

	task automatic send_word(word_t w);
		int unsigned gap;
		gap = pick_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		req_type    <= w.kind;
		table_index <= w.index;
		table_data  <= w.data;
		span_start  <= w.start;
		u_start     <= w.u0;
		v_start     <= w.v0;
		u_step      <= w.du;
		v_step      <= w.dv;
		x_first     <= w.x;
		row_in_view <= w.row;
		do @(posedge clk); while (in_ready !== 1'b1);
		predict_word(w);
		words_sent++;
	endtask

	// load whatever the pixel will look up before sending the draw word
	task automatic draw(word_t w);
		word_t               fill;
		logic [TileIdxW-1:0] t;
		t = texel_of(w);
		if (!tile_set[t]) begin
			fill = random_word(REQ_TILE);
			fill.index = 12'(t);
			send_word(fill);
		end
		if (!light_set[tile_mem[t]]) begin
			fill = random_word(REQ_LIGHT);
			fill.index[7:0] = tile_mem[t];
			send_word(fill);
		end
		if (!pal_set[light_mem[tile_mem[t]]]) begin
			fill = random_word(REQ_PALETTE);
			fill.index[7:0] = light_mem[tile_mem[t]];
			send_word(fill);
		end
		w.kind = REQ_DRAW;
		send_word(w);
	endtask

	task automatic run_span(int unsigned len, logic fresh, logic gentle);
		word_t w;
		for (int unsigned i = 0; i < len; i++) begin
			w = random_word(REQ_DRAW);
			w.start = fresh && (i == 0);
			if (gentle) begin
				w.du = small_step();
				w.dv = small_step();
			end
			draw(w);
		end
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (expected_pixels.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic set_config(logic ld, logic [7:0] wx, logic [6:0] wy);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_index <= CFG_LOW_DETAIL;
		cfg_data  <= {7'd0, ld};
		@(posedge clk);
		cfg_index <= CFG_WINDOW_X;
		cfg_data  <= wx;
		@(posedge clk);
		cfg_index <= CFG_WINDOW_Y;
		cfg_data  <= {1'b0, wy};
		@(posedge clk);
		cfg_we <= 1'b0;
		detail_low = ld;
		win_x = wx;
		win_y = wy;
	endtask

	task automatic report(string msg);
		errors++;
		if (errors <= 40)
			$display("MISMATCH: %s", msg);
	endtask

	// output side: random stalls
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if (!quiet && $urandom_range(0, 7) == 0) begin
			stall_left = pick_gap();
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		pixel_t e;
		if (arst_n && out_valid === 1'b1 && out_ready) begin
			if (expected_pixels.size() == 0) begin
				report($sformatf("pixel with nothing pending, addr %h", pixel_address));
			end else begin
				e = expected_pixels.pop_front();
				pixels_checked++;
				if (pixel_address !== e.addr)
					report($sformatf("pixel %0d addr %h, want %h",
						pixels_checked, pixel_address, e.addr));
				if (pixel_data !== e.data)
					report($sformatf("pixel %0d data %h, want %h",
						pixels_checked, pixel_data, e.data));
				if (wide_write !== e.wide)
					report($sformatf("pixel %0d wide %b, want %b",
						pixels_checked, wide_write, e.wide));
			end
		end
	end

	initial begin
		while (cycle_count < CycleLimit) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles, %0d pixels pending", cycle_count,
			expected_pixels.size());
		$display("span_texture_map_tb failed");
		$finish;
	end

	// zeroed accumulators and address right out of reset
	task automatic test_startup_draw();
		word_t w;
		w = random_word(REQ_DRAW);
		w.start = 1'b0;
		draw(w);
		draw(w);
	endtask

	task automatic test_field_extremes();
		word_t w;
		set_config(1'b0, 8'd0, 7'd0);
		w = random_word(REQ_TILE);
		w.index = 12'hFFF;
		w.data = 32'hFFFF_FFFF;
		send_word(w);
		w.index = 12'h000;
		w.data = 32'h0;
		send_word(w);
		w = random_word(REQ_LIGHT);
		w.index = 12'hFFF;
		w.data = 32'hFFFF_FFFF;
		send_word(w);
		w.index = 12'h000;
		w.data = 32'h0;
		send_word(w);
		w = random_word(REQ_PALETTE);
		w.index = 12'hFFF;
		w.data = 32'hFFFF_FFFF;
		send_word(w);
		w.index = 12'h000;
		w.data = 32'h0;
		send_word(w);

		w = random_word(REQ_DRAW);
		w.start = 1'b1;
		w.u0 = 32'h0;
		w.v0 = 32'h0;
		w.du = 32'h7FFF_FFFF;
		w.dv = 32'h8000_0000;
		w.x = 9'd0;
		w.row = 8'd0;
		draw(w);
		w.start = 1'b0;
		draw(w);
		draw(w);

		set_config(1'b1, 8'd160, 7'd84);
		w.start = 1'b1;
		w.u0 = 32'hFFFF_FFFF;
		w.v0 = 32'h7FFF_FFFF;
		w.du = 32'hFFFF_FFFF;
		w.dv = 32'h8000_0000;
		w.x = 9'd319;
		w.row = 8'd199;
		draw(w);
		w.start = 1'b0;
		draw(w);
		draw(w);
	endtask

	task automatic test_detail_switch();
		set_config(1'b0, 8'd37, 7'd11);
		run_span(3, 1'b1, 1'b1);
		set_config(1'b1, 8'd37, 7'd11);
		run_span(3, 1'b0, 1'b1);
		set_config(1'b0, 8'd37, 7'd11);
		run_span(2, 1'b0, 1'b1);
	endtask

	// window and span fields at their full widths give the highest start address
	task automatic test_address_top();
		word_t w;
		set_config(1'b1, 8'd255, 7'd127);
		w = random_word(REQ_DRAW);
		w.start = 1'b1;
		w.du = 32'h0001_0000;
		w.dv = 32'h0;
		w.x = 9'd511;
		w.row = 8'd255;
		draw(w);
		w.start = 1'b0;
		repeat (3) draw(w);
		set_config(1'b0, 8'd255, 7'd127);
		w.start = 1'b1;
		draw(w);
		w.start = 1'b0;
		draw(w);
	endtask

	task automatic test_random_traffic();
		word_t       w;
		int unsigned first_word;
		int unsigned len;
		int unsigned pick;
		bit          paused;
		paused = 1'b0;
		for (int phase = 0; phase < 5; phase++) begin
			case (phase)
				0: set_config(1'b0, 8'd0, 7'd0);
				1: set_config(1'b1, 8'd160, 7'd84);
				2: set_config(1'b0, 8'd160, 7'd0);
				3: set_config(1'b1, 8'd0, 7'd84);
				default: set_config(1'($urandom), 8'($urandom_range(0, 160)),
					7'($urandom_range(0, 84)));
			endcase
			quiet = (phase == 2);
			first_word = words_sent;
			while (words_sent - first_word < PhaseWords) begin
				pick = $urandom_range(0, 99);
				if (pick < 15) begin
					w = random_word(req_t'($urandom_range(0, 2)));
					send_word(w);
				end else if (pick < 22) begin
					// continue whatever span is current, no reload
					len = $urandom_range(1, 4);
					run_span(len, 1'b0, 1'b0);
				end else begin
					len = $urandom_range(1, 10);
					run_span(len, 1'b1, pick < 80);
				end
				if (phase == 1 && !paused && words_sent - first_word >= PhaseWords / 2) begin
					paused = 1'b1;
					wait_idle();
				end
			end
		end
		quiet = 1'b0;
	endtask

	initial begin
		quiet = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_startup_draw();
		test_field_extremes();
		test_detail_switch();
		test_address_top();
		test_random_traffic();
		wait_idle();
		$display("checked %0d pixels from %0d spans, %0d words sent, %0d table words",
			pixels_checked, spans_started, words_sent, table_writes);
		$display("both detail modes, window extremes and full-width start fields were run");
		if (errors == 0) begin
			$display("span_texture_map_tb passed");
		end else begin
			$display("span_texture_map_tb failed");
		end
		$finish;
	end

endmodule
